// File: hw/rtl/wsh_pkg.sv
// Shared types and constants for the windowed statistics and histogram unit.
// Used by every module under hw/rtl; depends on nothing else.
package wsh_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_DECIM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAUSE = 1'b1;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	localparam logic [2:0] DM_G1   = 3'd0;
	localparam logic [2:0] DM_G3   = 3'd1;
	localparam logic [2:0] DM_G15  = 3'd2;
	localparam logic [2:0] DM_G60  = 3'd3;
	localparam logic [2:0] DM_G180 = 3'd4;

	// Shared divider geometry.
	localparam int DIV_DW = 64;
	localparam int DIV_RW = 25;
	localparam int DIV_SW = 7;

	// Square root unit geometry.
	localparam int SQ_W     = 48;
	localparam int SQ_RW    = 24;
	localparam int SQ_STEPS = 24;
	localparam int SQ_CW    = 5;

	typedef enum logic [4:0] {
		S_IDLE, S_AVG, S_AVGW, S_WR, S_P1I, S_P1, S_MEAN, S_MEANW, S_SQ, S_SQW,
		S_VAR, S_SQRT, S_SQRTW, S_CLRI, S_CLR, S_HI, S_HRD, S_HMUL, S_HDIV, S_HDW,
		S_HBRD, S_HBWR, S_OI, S_ORD, S_OSHOW
	} state_t;

	typedef struct packed {
		logic take;
		logic avg_go;
		logic win_wr;
		logic p1_init;
		logic p1_run;
		logic mean_go;
		logic mean_lat;
		logic sq_go;
		logic var_calc;
		logic sqrt_go;
		logic std_lat;
		logic clr_init;
		logic clr_run;
		logic h_init;
		logic h_rd;
		logic h_mul;
		logic h_div;
		logic h_brd;
		logic h_bwr;
		logic o_init;
		logic o_rd;
		logic o_next;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic div_busy;
		logic sq_busy;
		logic p1_done;
		logic flat;
		logic h_more;
		logic k_last;
	} sts_t;

	function automatic logic [7:0] grp_size(input logic [2:0] mode);
		logic [7:0] r;
		unique case (mode)
			DM_G1:   r = 8'd1;
			DM_G3:   r = 8'd3;
			DM_G15:  r = 8'd15;
			DM_G60:  r = 8'd60;
			DM_G180: r = 8'd180;
			default: r = 8'd1;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/wsh_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on wsh_pkg for its widths.
module wsh_div import wsh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [DIV_RW-1:0] rem_init,
	input  logic [DIV_DW-1:0] dq_init,
	input  logic [DIV_RW-1:0] divisor,
	input  logic [DIV_SW-1:0] steps,
	output logic              busy,
	output logic [DIV_DW-1:0] quot
);

	logic [DIV_RW-1:0] rem_q;
	logic [DIV_DW-1:0] dq_q;
	logic [DIV_RW-1:0] dv_q;
	logic [DIV_SW-1:0] cnt_q;
	logic [DIV_RW:0]   trial;
	logic [DIV_RW:0]   diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, dq_q[DIV_DW-1]};
		ge    = trial >= {1'b0, dv_q};
		diff  = trial - {1'b0, dv_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// The quotient bits shift in at the bottom as the dividend leaves the top.
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= rem_init;
			dq_q  <= dq_init;
			dv_q  <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
			dq_q  <= {dq_q[DIV_DW-2:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = dq_q;

endmodule

// File: hw/rtl/wsh_sqrt.sv
// Bitwise integer square root, one result bit per cycle.
// Depends on wsh_pkg for its widths.
module wsh_sqrt import wsh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [SQ_W-1:0]  x,
	output logic             busy,
	output logic [SQ_RW-1:0] root
);

	logic [SQ_W-1:0]  v_q;
	logic [SQ_W-1:0]  res_q;
	logic [SQ_W-1:0]  bit_q;
	logic [SQ_CW-1:0] cnt_q;
	logic [SQ_W-1:0]  t;

	assign t = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= SQ_CW'(SQ_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			v_q   <= x;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (cnt_q != '0) begin
			if (v_q >= t) begin
				v_q   <= v_q - t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = cnt_q != '0;
	assign root = res_q[SQ_RW-1:0];

endmodule

// File: hw/rtl/wsh_dp.sv
// Datapath: sample grouping, window memory, statistics, histogram bins.
// Depends on wsh_pkg, wsh_div and wsh_sqrt; driven by wsh_ctrl commands.
module wsh_dp import wsh_pkg::*; #(
	parameter int WINDOW    = 256,
	parameter int HIST_BINS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  opcode,
	input  logic signed [15:0]    sample,
	input  logic                  sample_ok,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [5:0]            bin_index,
	output logic [8:0]            bin_count,
	output logic                  last_bin,
	output logic signed [23:0]    window_min,
	output logic signed [23:0]    window_max,
	output logic signed [23:0]    window_mean,
	output logic [22:0]           window_std,
	output logic [8:0]            point_count
);

	localparam int AW   = $clog2(WINDOW);
	localparam int NW   = $clog2(WINDOW + 1);
	localparam int KW   = $clog2(HIST_BINS);
	localparam int SUMW = 24 + AW;
	localparam int SQW  = 47 + AW;
	localparam int PW   = 25 + KW;

	// Group and window control.
	logic [2:0]         decim_q;
	logic               pause_q;
	logic               first_q;
	logic signed [23:0] gsum_q;
	logic [7:0]         gcnt_q;
	logic [NW-1:0]      n_q;
	logic [AW-1:0]      wp_q;
	logic [AW-1:0]      ptr_q;
	logic [NW-1:0]      cnt_q;
	logic [KW-1:0]      k_q;
	logic               rv_s1;
	logic               sv_s2;

	logic signed [23:0] s_ext;
	logic               live;
	logic [7:0]         cnt_next;
	logic [AW-1:0]      wp_next;
	logic [AW-1:0]      ptr_next;
	logic [NW:0]        start_full;
	logic [AW-1:0]      start;
	logic               rd_en;

	// Arithmetic registers.
	logic signed [23:0]     win_mem [WINDOW];
	logic signed [23:0]     win_rd_q;
	logic [46:0]            sq_s2;
	logic signed [23:0]     mn_q;
	logic signed [23:0]     mx_q;
	logic signed [SUMW-1:0] sum_q;
	logic [SQW-1:0]         sumsq_q;
	logic signed [23:0]     mean_q;
	logic [SQ_W-1:0]        msq_q;
	logic [SQ_W-1:0]        var_q;
	logic [22:0]            std_q;
	logic [PW-1:0]          p_q;
	logic [KW-1:0]          j_q;
	logic [8:0]             bin_mem [HIST_BINS];
	logic [8:0]             bin_rd_q;

	logic [23:0]       gmag;
	logic [SUMW-1:0]   smag;
	logic signed [23:0] avg;
	logic [24:0]       range;
	logic [24:0]       dlt;
	logic [KW:0]       jraw;
	logic [KW-1:0]     jc;
	logic              bin_we;
	logic [KW-1:0]     bin_wa;
	logic [8:0]        bin_wd;
	logic              bin_re;
	logic [KW-1:0]     bin_ra;
	logic [DIV_DW:0]   vdiff;

	// Divider and root unit hookup.
	logic              div_go;
	logic [DIV_RW-1:0] div_rem;
	logic [DIV_DW-1:0] div_dq;
	logic [DIV_RW-1:0] div_dv;
	logic [DIV_SW-1:0] div_steps;
	logic              div_busy;
	logic [DIV_DW-1:0] quot;
	logic              sq_busy;
	logic [SQ_RW-1:0]  root;

	assign s_ext    = {{8{sample[15]}}, sample};
	assign live     = (opcode == OP_SAMPLE) && (!pause_q || first_q) && sample_ok;
	assign cnt_next = first_q ? 8'd1 : gcnt_q + 8'd1;
	assign wp_next  = (wp_q == AW'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
	assign ptr_next = (ptr_q == AW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;

	// Oldest valid entry: the write pointer stepped back by the point count.
	always_comb begin
		if ((NW + 1)'(wp_q) >= (NW + 1)'(n_q)) begin
			start_full = (NW + 1)'(wp_q) - (NW + 1)'(n_q);
		end else begin
			start_full = (NW + 1)'(wp_q) + (NW + 1)'(WINDOW) - (NW + 1)'(n_q);
		end
		start = start_full[AW-1:0];
	end

	assign rd_en = (cmd.p1_run && cnt_q != '0) || cmd.h_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decim_q <= DM_G1;
			pause_q <= 1'b0;
			first_q <= 1'b1;
			gsum_q  <= '0;
			gcnt_q  <= '0;
			n_q     <= '0;
			wp_q    <= '0;
		end else begin
			if (cmd.take) begin
				if (opcode == OP_CLEAR) begin
					first_q <= 1'b1;
					n_q     <= '0;
				end else if (live) begin
					gsum_q <= first_q ? s_ext : gsum_q + s_ext;
					gcnt_q <= cnt_next;
				end
			end
			if (cmd.win_wr) begin
				gsum_q  <= '0;
				gcnt_q  <= '0;
				first_q <= 1'b0;
				wp_q    <= wp_next;
				if (n_q < NW'(WINDOW)) begin
					n_q <= n_q + 1'b1;
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_DECIM) begin
					if (cfg_data != decim_q) begin
						decim_q <= cfg_data;
						first_q <= 1'b1;
						n_q     <= '0;
					end
				end else begin
					pause_q <= cfg_data[0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cnt_q <= '0;
			rv_s1 <= 1'b0;
			sv_s2 <= 1'b0;
			k_q   <= '0;
		end else begin
			if (cmd.p1_init || cmd.h_init) begin
				ptr_q <= start;
				cnt_q <= n_q;
			end else if (rd_en) begin
				ptr_q <= ptr_next;
				cnt_q <= cnt_q - 1'b1;
			end
			rv_s1 <= cmd.p1_run && cnt_q != '0;
			sv_s2 <= rv_s1;
			if (cmd.clr_init || cmd.o_init) begin
				k_q <= '0;
			end else if (cmd.clr_run || cmd.o_next) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Averages are divided as magnitudes and the sign is put back afterwards.
	assign gmag = gsum_q[23] ? 24'(-gsum_q) : 24'(gsum_q);
	assign smag = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
	assign avg  = gsum_q[23] ? -$signed(quot[23:0]) : $signed(quot[23:0]);

	always_ff @(posedge clk) begin
		if (cmd.win_wr) begin
			win_mem[wp_q] <= avg;
		end
		if (rd_en) begin
			win_rd_q <= win_mem[ptr_q];
		end
	end

	assign range = {mx_q[23], mx_q} - {mn_q[23], mn_q};
	assign dlt   = {win_rd_q[23], win_rd_q} - {mn_q[23], mn_q};
	assign vdiff = {1'b0, quot} - (DIV_DW + 1)'(msq_q);

	always_ff @(posedge clk) begin
		sq_s2 <= 47'(win_rd_q * win_rd_q);
		msq_q <= SQ_W'(mean_q * mean_q);
		if (cmd.p1_init) begin
			mn_q    <= 24'sh7FFFFF;
			mx_q    <= -24'sh800000;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else begin
			if (rv_s1) begin
				if (win_rd_q < mn_q) begin
					mn_q <= win_rd_q;
				end
				if (win_rd_q > mx_q) begin
					mx_q <= win_rd_q;
				end
				sum_q <= sum_q + SUMW'(win_rd_q);
			end
			if (sv_s2) begin
				sumsq_q <= sumsq_q + SQW'(sq_s2);
			end
		end
		if (cmd.mean_lat) begin
			mean_q <= sum_q[SUMW-1] ? -$signed(quot[23:0]) : $signed(quot[23:0]);
		end
		// A negative variance comes out as zero.
		if (cmd.var_calc) begin
			var_q <= vdiff[DIV_DW] ? '0 : vdiff[SQ_W-1:0];
		end
		if (cmd.std_lat) begin
			std_q <= root[SQ_RW-1] ? 23'h7FFFFF : root[22:0];
		end
		if (cmd.h_mul) begin
			p_q <= PW'(dlt) * PW'(HIST_BINS - 1);
		end
		if (cmd.h_brd) begin
			j_q <= jc;
		end
	end

	always_comb begin
		div_go    = cmd.avg_go || cmd.mean_go || cmd.sq_go || cmd.h_div;
		div_rem   = '0;
		div_dq    = '0;
		div_dv    = '0;
		div_steps = '0;
		if (cmd.avg_go) begin
			div_dq    = {gmag, 8'h00, 32'h0};
			div_dv    = DIV_RW'(gcnt_q);
			div_steps = DIV_SW'(32);
		end else if (cmd.mean_go) begin
			div_dq    = {smag, {(DIV_DW - SUMW){1'b0}}};
			div_dv    = DIV_RW'(n_q);
			div_steps = DIV_SW'(SUMW);
		end else if (cmd.sq_go) begin
			div_dq    = {sumsq_q, {(DIV_DW - SQW){1'b0}}};
			div_dv    = DIV_RW'(n_q);
			div_steps = DIV_SW'(SQW);
		end else if (cmd.h_div) begin
			// The bin quotient is below 2**KW, so only KW steps are needed.
			div_rem   = p_q[PW-1:KW];
			div_dq    = {p_q[KW-1:0], {(DIV_DW - KW){1'b0}}};
			div_dv    = range;
			div_steps = DIV_SW'(KW);
		end
	end

	wsh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.rem_init (div_rem),
		.dq_init  (div_dq),
		.divisor  (div_dv),
		.steps    (div_steps),
		.busy     (div_busy),
		.quot     (quot)
	);

	wsh_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.sqrt_go),
		.x      (var_q),
		.busy   (sq_busy),
		.root   (root)
	);

	// Bin 0 is never hit: the bin index is offset by one and clamped at the top.
	assign jraw = (KW + 1)'(quot[KW-1:0]) + 1'b1;
	assign jc   = (jraw > (KW + 1)'(HIST_BINS - 1)) ? KW'(HIST_BINS - 1) : jraw[KW-1:0];

	always_comb begin
		bin_we = cmd.clr_run || cmd.h_bwr;
		bin_wa = cmd.clr_run ? k_q : j_q;
		bin_wd = cmd.clr_run ? 9'd0 : ((bin_rd_q == 9'd511) ? 9'd511 : bin_rd_q + 9'd1);
		bin_re = cmd.h_brd || cmd.o_rd;
		bin_ra = cmd.h_brd ? jc : k_q;
	end

	always_ff @(posedge clk) begin
		if (bin_we) begin
			bin_mem[bin_wa] <= bin_wd;
		end
		if (bin_re) begin
			bin_rd_q <= bin_mem[bin_ra];
		end
	end

	always_comb begin
		sts.emit     = live && (first_q || cnt_next >= grp_size(decim_q));
		sts.div_busy = div_busy;
		sts.sq_busy  = sq_busy;
		sts.p1_done  = (cnt_q == '0) && !rv_s1 && !sv_s2;
		sts.flat     = mx_q == mn_q;
		sts.h_more   = cnt_q != '0;
		sts.k_last   = k_q == KW'(HIST_BINS - 1);
	end

	assign bin_index   = 6'(k_q);
	assign bin_count   = bin_rd_q;
	assign last_bin    = sts.k_last;
	assign window_min  = mn_q;
	assign window_max  = mx_q;
	assign window_mean = mean_q;
	assign window_std  = std_q;
	assign point_count = (32'(n_q) > 32'd511) ? 9'd511 : 9'(n_q);

endmodule

// File: hw/rtl/wsh_ctrl.sv
// Sequencing state machine for the statistics and histogram unit.
// Depends on wsh_pkg; issues cmd_t to wsh_dp and reads its sts_t.
module wsh_ctrl import wsh_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid && sts.emit) state_nx = S_AVG;
			S_AVG:   state_nx = S_AVGW;
			S_AVGW:  if (!sts.div_busy) state_nx = S_WR;
			S_WR:    state_nx = S_P1I;
			S_P1I:   state_nx = S_P1;
			S_P1:    if (sts.p1_done) state_nx = S_MEAN;
			S_MEAN:  state_nx = S_MEANW;
			S_MEANW: if (!sts.div_busy) state_nx = S_SQ;
			S_SQ:    state_nx = S_SQW;
			S_SQW:   if (!sts.div_busy) state_nx = S_VAR;
			S_VAR:   state_nx = S_SQRT;
			S_SQRT:  state_nx = S_SQRTW;
			S_SQRTW: if (!sts.sq_busy) state_nx = S_CLRI;
			S_CLRI:  state_nx = S_CLR;
			S_CLR:   if (sts.k_last) state_nx = sts.flat ? S_OI : S_HI;
			S_HI:    state_nx = S_HRD;
			S_HRD:   state_nx = S_HMUL;
			S_HMUL:  state_nx = S_HDIV;
			S_HDIV:  state_nx = S_HDW;
			S_HDW:   if (!sts.div_busy) state_nx = S_HBRD;
			S_HBRD:  state_nx = S_HBWR;
			S_HBWR:  state_nx = sts.h_more ? S_HRD : S_OI;
			S_OI:    state_nx = S_ORD;
			S_ORD:   state_nx = S_OSHOW;
			S_OSHOW: if (out_ready) state_nx = sts.k_last ? S_IDLE : S_ORD;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			S_AVG:  cmd.avg_go = 1'b1;
			S_WR:   cmd.win_wr = 1'b1;
			S_P1I:  cmd.p1_init = 1'b1;
			S_P1:   cmd.p1_run = 1'b1;
			S_MEAN: cmd.mean_go = 1'b1;
			S_SQ: begin
				cmd.mean_lat = 1'b1;
				cmd.sq_go    = 1'b1;
			end
			S_VAR:  cmd.var_calc = 1'b1;
			S_SQRT: cmd.sqrt_go = 1'b1;
			S_CLRI: begin
				cmd.std_lat  = 1'b1;
				cmd.clr_init = 1'b1;
			end
			S_CLR:  cmd.clr_run = 1'b1;
			S_HI:   cmd.h_init = 1'b1;
			S_HRD:  cmd.h_rd = 1'b1;
			S_HMUL: cmd.h_mul = 1'b1;
			S_HDIV: cmd.h_div = 1'b1;
			S_HBRD: cmd.h_brd = 1'b1;
			S_HBWR: cmd.h_bwr = 1'b1;
			S_OI:   cmd.o_init = 1'b1;
			S_ORD:  cmd.o_rd = 1'b1;
			S_OSHOW: begin
				out_valid  = 1'b1;
				cmd.o_next = out_ready && !sts.k_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// File: hw/rtl/windowed_stats_histogram_unit.sv
// Windowed statistics and histogram unit: sample averaging, a sliding window
// of averages, and per-average min/max/mean/std plus a histogram of the window.
// Usage:
//   Input channel (in_valid/in_ready) carries opcode, sample and sample_ok.
//   opcode clear restarts the window; good samples are grouped per decim_mode.
//   Each completed group yields HIST_BINS output beats (out_valid/out_ready),
//   one per bin, with the window statistics repeated on every beat and
//   last_bin set on the final one. Inputs that complete no group give none.
//   Configuration (cfg_valid/cfg_ready) is always ready: index 0 decim_mode,
//   index 1 pause. Write it only while the unit is idle.
//   One item is processed at a time; in_ready is high only while idle.
//   All divisions go through the shared serial divider, and the window memory
//   is read one entry at a time for the statistics and for the histogram.
//   A stalled receiver holds the current beat; nothing is dropped.
//   Reset empties the window and returns the unit to idle; no clearing pass.
module windowed_stats_histogram_unit import wsh_pkg::*; #(
	parameter int WINDOW    = 256,
	parameter int HIST_BINS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic signed [15:0]    sample,
	input  logic                  sample_ok,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [5:0]            bin_index,
	output logic [8:0]            bin_count,
	output logic                  last_bin,
	output logic signed [23:0]    window_min,
	output logic signed [23:0]    window_max,
	output logic signed [23:0]    window_mean,
	output logic [22:0]           window_std,
	output logic [8:0]            point_count,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	wsh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	wsh_dp #(
		.WINDOW    (WINDOW),
		.HIST_BINS (HIST_BINS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (opcode),
		.sample      (sample),
		.sample_ok   (sample_ok),
		.cfg_we      (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.bin_index   (bin_index),
		.bin_count   (bin_count),
		.last_bin    (last_bin),
		.window_min  (window_min),
		.window_max  (window_max),
		.window_mean (window_mean),
		.window_std  (window_std),
		.point_count (point_count)
	);

`ifndef SYNTH
	// No new sample is taken while a result beat is being offered.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input accepted during output");

	// The last bin ends the result run.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_bin |=> !out_valid)
		else $error("output continued after last bin");

	// A clear causes no work.
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_CLEAR |=> in_ready)
		else $error("clear left the unit busy");
`endif

endmodule

// File: tb/tb.sv
// Testbench for windowed_stats_histogram_unit: sample, clear and config stimulus
// with a built-in statistics and histogram predictor. Depends on wsh_pkg and the unit.
`timescale 1ns / 1ps

module tb;
	import wsh_pkg::*;

	localparam int WIN   = 256;
	localparam int BINS  = 32;
	localparam int DRAIN = 4000;
	localparam longint CYCLE_LIMIT = 6000000;

	typedef struct {
		logic [5:0]         idx;
		logic [8:0]         cnt;
		logic               lst;
		logic signed [23:0] mn;
		logic signed [23:0] mx;
		logic signed [23:0] mean;
		logic [22:0]        sd;
		logic [8:0]         pc;
	} bin_beat_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	logic opcode = OP_SAMPLE;
	logic signed [15:0] sample = '0;
	logic sample_ok = 0;
	logic out_valid, out_ready = 0;
	logic [5:0] bin_index;
	logic [8:0] bin_count;
	logic last_bin;
	logic signed [23:0] window_min, window_max, window_mean;
	logic [22:0] window_std;
	logic [8:0] point_count;
	logic cfg_valid = 0, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_DECIM;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	windowed_stats_histogram_unit DUT (.*);

	always #4 clk = ~clk;

	// Predictor state.
	logic [2:0] cur_mode;
	logic cur_pause;
	logic signed [23:0] win_vals [WIN];
	longint acc_sum;
	int unsigned acc_cnt;
	int unsigned npts;
	bit fresh;

	bin_beat_t hist_q [$];
	int errors = 0;
	int beats_seen = 0;
	int averages = 0;
	int items_sent = 0;
	longint cycles = 0;
	bit ready_calm = 0;

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic int unsigned group_len(logic [2:0] m);
		case (m)
			DM_G3:   return 3;
			DM_G15:  return 15;
			DM_G60:  return 60;
			DM_G180: return 180;
			default: return 1;
		endcase
	endfunction

	task automatic predict_stats(logic op, logic signed [15:0] s, logic ok);
		longint avg, total, mean, var_q, range, j;
		longint unsigned sq_total, sd;
		logic signed [23:0] mn, mx, y;
		int unsigned first, hcount [BINS];
		bin_beat_t b;
		if (op == OP_CLEAR) begin
			fresh = 1;
			npts = 0;
			return;
		end
		if (cur_pause && !fresh)
			return;
		if (!ok)
			return;
		if (fresh) begin
			acc_sum = s;
			acc_cnt = 1;
		end else begin
			acc_sum += s;
			acc_cnt++;
			if (acc_cnt < group_len(cur_mode))
				return;
		end
		avg = (acc_sum * 256) / longint'(acc_cnt);
		acc_sum = 0;
		acc_cnt = 0;
		if (fresh) begin
			for (int i = 0; i < WIN; i++)
				win_vals[i] = 24'(avg);
			fresh = 0;
		end else begin
			for (int i = 0; i < WIN - 1; i++)
				win_vals[i] = win_vals[i + 1];
			win_vals[WIN - 1] = 24'(avg);
		end
		if (npts < WIN)
			npts++;
		first = WIN - npts;
		mn = win_vals[first];
		mx = win_vals[first];
		total = 0;
		sq_total = 0;
		for (int i = first; i < WIN; i++) begin
			y = win_vals[i];
			if (y < mn) mn = y;
			if (y > mx) mx = y;
			total += y;
			sq_total += longint'(y) * longint'(y);
		end
		mean = total / longint'(npts);
		var_q = longint'(sq_total / npts) - mean * mean;
		if (var_q < 0)
			var_q = 0;
		sd = floor_sqrt(var_q);
		if (sd > 8388607)
			sd = 8388607;
		for (int i = 0; i < BINS; i++)
			hcount[i] = 0;
		if (mx != mn) begin
			range = longint'(mx) - longint'(mn);
			for (int i = first; i < WIN; i++) begin
				j = ((longint'(win_vals[i]) - mn) * (BINS - 1)) / range + 1;
				if (j > BINS - 1) j = BINS - 1;
				hcount[j]++;
			end
		end
		averages++;
		for (int i = 0; i < BINS; i++) begin
			b.idx  = 6'(i);
			b.cnt  = (hcount[i] > 511) ? 9'd511 : 9'(hcount[i]);
			b.lst  = (i == BINS - 1);
			b.mn   = mn;
			b.mx   = mx;
			b.mean = mean[23:0];
			b.sd   = sd[22:0];
			b.pc   = 9'(npts);
			hist_q.push_back(b);
		end
	endtask

	// Result checker: every accepted beat is matched against the oldest prediction.
	always @(posedge clk) begin
		bin_beat_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout at %0t", $time);
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			beats_seen++;
			if (hist_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat bin %0d", $time, bin_index);
			end else begin
				e = hist_q.pop_front();
				if (bin_index !== e.idx || bin_count !== e.cnt || last_bin !== e.lst ||
						window_min !== e.mn || window_max !== e.mx ||
						window_mean !== e.mean || window_std !== e.sd ||
						point_count !== e.pc) begin
					errors++;
					$display("%0t: mismatch exp idx=%0d cnt=%0d last=%0b min=%0d max=%0d",
						$time, e.idx, e.cnt, e.lst, e.mn, e.mx);
					$display("%0t:          exp mean=%0d std=%0d pc=%0d",
						$time, e.mean, e.sd, e.pc);
					$display("%0t:          act idx=%0d cnt=%0d last=%0b min=%0d max=%0d",
						$time, bin_index, bin_count, last_bin, window_min, window_max);
					$display("%0t:          act mean=%0d std=%0d pc=%0d",
						$time, window_mean, window_std, point_count);
				end
			end
		end
	end

	// Receiver stalls about one cycle in ten unless in a calm stretch.
	always @(negedge clk)
		out_ready <= ready_calm ? 1'b1 : ($urandom_range(99) >= 10);

	task automatic send_item(logic op, logic signed [15:0] s, logic ok);
		if (!ready_calm && $urandom_range(99) < 10) begin
			@(negedge clk);
			in_valid = 0;
			repeat ($urandom_range(6)) @(negedge clk);
		end else
			@(negedge clk);
		opcode = op;
		sample = s;
		sample_ok = ok;
		in_valid = 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_stats(op, s, ok);
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 0;
		while (hist_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		wait_drained();
		@(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_DECIM) begin
			if (val != cur_mode) begin
				cur_mode = val;
				fresh = 1;
				npts = 0;
			end
		end else
			cur_pause = val[0];
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2, 3: return 16'($urandom_range(200) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_beats(int count);
		int r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			if (r < 2)
				send_item(OP_CLEAR, 16'($urandom), 1'($urandom));
			else if (r < 7)
				send_item(OP_SAMPLE, 16'($urandom), 1'b0);
			else
				send_item(OP_SAMPLE, pick_sample(), 1'b1);
		end
	endtask

	task automatic test_extremes();
		send_item(OP_SAMPLE, 16'sh8000, 1'b1);
		send_item(OP_SAMPLE, 16'sh7FFF, 1'b1);
		send_item(OP_SAMPLE, 16'sh7FFF, 1'b1);
		send_item(OP_SAMPLE, 16'sh0000, 1'b0);
		send_item(OP_SAMPLE, -16'sd1, 1'b1);
		send_item(OP_CLEAR, 16'sh7FFF, 1'b1);
		send_item(OP_SAMPLE, 16'sd5, 1'b1);
		send_item(OP_SAMPLE, 16'sd5, 1'b1);
		send_item(OP_SAMPLE, 16'sh8000, 1'b1);
	endtask

	task automatic test_pause();
		write_reg(CFG_PAUSE, 3'd1);
		send_item(OP_SAMPLE, 16'sd100, 1'b1);
		send_item(OP_SAMPLE, 16'sd200, 1'b1);
		send_item(OP_CLEAR, 16'sd0, 1'b0);
		send_item(OP_SAMPLE, 16'sd0, 1'b0);
		send_item(OP_SAMPLE, -16'sd300, 1'b1);
		send_item(OP_SAMPLE, 16'sd7, 1'b1);
		write_reg(CFG_PAUSE, 3'd0);
	endtask

	task automatic test_odd_modes();
		write_reg(CFG_DECIM, 3'd7);
		send_item(OP_SAMPLE, 16'sd1, 1'b1);
		send_item(OP_SAMPLE, 16'sd2, 1'b1);
		write_reg(CFG_DECIM, 3'd5);
		send_item(OP_SAMPLE, -16'sd9, 1'b1);
		write_reg(CFG_DECIM, 3'd6);
		send_item(OP_SAMPLE, 16'sd3, 1'b1);
		write_reg(CFG_DECIM, DM_G3);
		write_reg(CFG_DECIM, DM_G3);
	endtask

	task automatic test_mode(logic [2:0] m, int count);
		write_reg(CFG_DECIM, m);
		random_beats(count);
	endtask

	initial begin
		cur_mode = DM_G1;
		cur_pause = 0;
		acc_sum = 0;
		acc_cnt = 0;
		npts = 0;
		fresh = 1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_extremes();
		test_pause();
		test_odd_modes();
		test_mode(DM_G1, 35);
		ready_calm = 1;
		random_beats(30);
		ready_calm = 0;
		test_mode(DM_G3, 45);
		test_mode(DM_G15, 35);
		test_mode(DM_G60, 64);
		test_mode(DM_G180, 186);
		test_mode(DM_G1, 10);
		wait_drained();

		$display("Sent %0d items over all five group sizes, pause and clear.", items_sent);
		$display("Produced %0d averages and checked %0d result beats.", averages, beats_seen);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
